/* src/pfdr_pkg.sv */
// shared types, constants and default palette function for the dirty-rect framebuffer
// no dependencies
package pfdr_pkg;
  localparam int MAX_WIDTH = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PALETTE_ENTRIES = 256;
  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int DW = XW + 1;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SAW = $clog2(STORE_DEPTH);
  localparam int PAW = $clog2(PALETTE_ENTRIES);
  localparam int OFFW = DW + DW;
  localparam logic [20:0] PIX_BASE = 21'h1000;
  localparam logic [20:0] PAL_BASE = 21'h0C00;
  localparam logic [7:0] PAL_MASK = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ = 2'd0,
    OP_WRITE = 2'd1,
    OP_DRAW = 2'd2,
    OP_SCAN = 2'd3
  } op_t;

  localparam logic CFG_WIDTH = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic load;
    logic div_start;
    logic mem_rd;
    logic mem_wr;
    logic pal_wr;
    logic pal_lookup;
    logic capture;
    logic merge;
    logic draw;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic last_byte;
    logic all_read;
    logic init_busy;
    logic is_pix;
    logic is_pal;
    logic past_end;
    logic len_zero;
    logic scan_bad;
  } sts_t;

  function automatic logic [31:0] default_palette(input logic [7:0] i);
    logic [7:0] r, g, b, q;
    logic [2:0] ri, gi, bi;
    logic [7:0] k;
    r = 8'd0; g = 8'd0; b = 8'd0; ri = 3'd0; gi = 3'd0; bi = 3'd0; q = 8'd0;
    k = 8'd0;
    if (i >= 8'd240) begin
      q = i - 8'd240;
      default_palette = {8'd0, {3{q[3:0], q[3:0]}}};
    end else begin
      for (int n = 1; n < 6; n++) if (i >= 8'(40 * n)) ri = 3'(n);
      k = i - 8'(ri) * 8'd40;
      for (int n = 1; n < 8; n++) if (k >= 8'(5 * n)) gi = 3'(n);
      bi = 3'(k - 8'(gi) * 8'd5);
      case (ri)
        3'd0: r = 8'h00; 3'd1: r = 8'h33; 3'd2: r = 8'h66;
        3'd3: r = 8'h99; 3'd4: r = 8'hCC; default: r = 8'hFF;
      endcase
      case (gi)
        3'd0: g = 8'h00; 3'd1: g = 8'h24; 3'd2: g = 8'h49; 3'd3: g = 8'h6D;
        3'd4: g = 8'h92; 3'd5: g = 8'hB6; 3'd6: g = 8'hDB; default: g = 8'hFF;
      endcase
      case (bi)
        3'd0: b = 8'h00; 3'd1: b = 8'h40; 3'd2: b = 8'h80;
        3'd3: b = 8'hC0; default: b = 8'hFF;
      endcase
      default_palette = {8'd0, r, g, b};
    end
  endfunction
endpackage

/* src/pfdr_ram.sv */
// generic single-port ram with registered read
// no dependencies
module pfdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

/* src/pfdr_div.sv */
// restoring divider, one quotient bit per cycle
// depends on pfdr_pkg
module pfdr_div (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [pfdr_pkg::OFFW-1:0] dividend,
  input  logic [pfdr_pkg::DW-1:0] divisor,
  output logic [pfdr_pkg::OFFW-1:0] quotient,
  output logic [pfdr_pkg::DW-1:0] remainder,
  output logic done
);
  import pfdr_pkg::*;
  localparam int CW = $clog2(OFFW + 1);
  logic [CW-1:0] count;
  logic busy;
  logic [DW:0] trial;
  assign trial = {remainder, quotient[OFFW-1]} - {1'b0, divisor};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; count <= CW'(OFFW);
        quotient <= dividend; remainder <= '0;
      end else if (busy) begin
        if (!trial[DW]) begin
          remainder <= trial[DW-1:0];
          quotient <= {quotient[OFFW-2:0], 1'b1};
        end else begin
          remainder <= {remainder[DW-2:0], quotient[OFFW-1]};
          quotient <= {quotient[OFFW-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/pfdr_datapath.sv */
// datapath: item registers, pixel and palette memories, dirty rectangle, result
// depends on pfdr_pkg, pfdr_ram, pfdr_div
module pfdr_datapath (
  input  logic clk,
  input  logic rst,
  input  pfdr_pkg::cmd_t cmd,
  output pfdr_pkg::sts_t sts,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [10:0] cfg_data,
  input  logic [1:0] opcode,
  input  logic [20:0] address,
  input  logic [3:0] length,
  input  logic [63:0] write_data,
  output logic status,
  output logic [63:0] read_data,
  output logic rect_valid,
  output logic [9:0] rect_left,
  output logic [9:0] rect_top,
  output logic [9:0] rect_right,
  output logic [9:0] rect_bottom,
  output logic [31:0] pixel_color
);
  import pfdr_pkg::*;
  logic [DW-1:0] width, height, dim;
  logic [OFFW-1:0] total;
  logic [1:0] op;
  logic [20:0] addr;
  logic [3:0] len, idx;
  logic [63:0] wdata, rdata;
  logic [OFFW-1:0] off;
  logic [OFFW:0] off_end;
  logic dflag;
  logic [XW-1:0] dl, dr, x1;
  logic [YW-1:0] dt, db, y1;
  logic pal_sel;
  logic [PAW-1:0] pal_idx;
  logic [PAW-1:0] pal_addr, init_idx;
  logic [31:0] pal_q, pal_w;
  logic pal_we, pal_init;
  logic [7:0] pix_q;
  logic [OFFW-1:0] div_n, q;
  logic [DW-1:0] rem;
  logic [SAW-1:0] pix_addr;
  logic [OFFW-1:0] pix_off;

  always_comb begin
    dim = cfg_data[DW-1:0];
    if (cfg_data == 11'd0) dim = DW'(1);
    else if (cfg_index == CFG_HEIGHT && cfg_data > 11'(MAX_HEIGHT)) dim = DW'(MAX_HEIGHT);
    else if (cfg_index == CFG_WIDTH && cfg_data > 11'(MAX_WIDTH)) dim = DW'(MAX_WIDTH);
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= DW'(1024); height <= DW'(768);
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) width <= dim;
      else height <= dim;
    end
  end
  always_ff @(posedge clk) total <= width * height;

  assign off = OFFW'(addr - PIX_BASE);
  assign off_end = {1'b0, off} + (OFFW+1)'(len);
  assign sts.is_pix = addr >= PIX_BASE;
  assign sts.is_pal = addr >= PAL_BASE && (addr - PAL_BASE) <= 21'(PAL_MASK);
  assign sts.past_end = off_end > {1'b0, total};
  assign sts.scan_bad = !sts.is_pix || off >= total;
  assign sts.len_zero = len == 4'd0;
  assign sts.last_byte = idx + 4'd1 >= len;
  assign sts.all_read = idx >= len;
  assign sts.init_busy = pal_init;
  assign pal_idx = PAW'(addr - PAL_BASE);

  // byte walk counter, first byte at idx 0
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode; addr <= address; wdata <= write_data;
      len <= length > 4'd8 ? 4'd8 : length;
      idx <= '0; rdata <= '0;
    end else begin
      if (cmd.mem_rd || cmd.mem_wr) idx <= idx + 4'd1;
      if (cmd.capture) rdata[8*(idx-4'd1) +: 8] <= pix_q;
    end
  end

  assign pix_off = off + OFFW'(idx);
  assign pix_addr = pix_off[SAW-1:0];
  pfdr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_pix (
    .clk(clk), .we(cmd.mem_wr), .addr(pix_addr),
    .wdata(wdata[8*idx[2:0] +: 8]), .rdata(pix_q)
  );

  // palette preload sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      pal_init <= 1'b1; init_idx <= '0;
    end else if (pal_init) begin
      init_idx <= init_idx + 1'b1;
      if (init_idx == PAW'(PALETTE_ENTRIES - 1)) pal_init <= 1'b0;
    end
  end
  assign pal_sel = cmd.pal_lookup;
  assign pal_addr = pal_init ? init_idx : (pal_sel ? pix_q : pal_idx);
  assign pal_we = pal_init || cmd.pal_wr;
  assign pal_w = pal_init ? default_palette(init_idx) : wdata[31:0];
  pfdr_ram #(.WIDTH(32), .DEPTH(PALETTE_ENTRIES)) u_pal (
    .clk(clk), .we(pal_we), .addr(pal_addr), .wdata(pal_w), .rdata(pal_q)
  );

  // start/end coordinates by division
  logic phase;
  always_ff @(posedge clk) begin
    if (cmd.load) phase <= 1'b0;
    else if (sts.div_done) phase <= 1'b1;
  end
  assign div_n = phase ? OFFW'(off_end - 1'b1) : off;
  pfdr_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(div_n), .divisor(width),
    .quotient(q), .remainder(rem), .done(sts.div_done)
  );
  always_ff @(posedge clk) begin
    if (sts.div_done && !phase) begin
      x1 <= rem[XW-1:0]; y1 <= q[YW-1:0];
    end
  end

  logic [XW-1:0] mx1, mx2, x2;
  logic [YW-1:0] y2;
  assign x2 = rem[XW-1:0];
  assign y2 = q[YW-1:0];
  assign mx1 = (y1 != y2) ? '0 : x1;
  assign mx2 = (y1 != y2) ? XW'(width - 1'b1) : x2;
  always_ff @(posedge clk) begin
    if (rst) begin
      dflag <= 1'b1; dl <= '0; dt <= '0;
      dr <= XW'(1023); db <= YW'(767);
    end else if (cmd.merge) begin
      dflag <= 1'b1;
      if (!dflag || mx1 < dl) dl <= mx1;
      if (!dflag || y1 < dt) dt <= y1;
      if (!dflag || mx2 > dr) dr <= mx2;
      if (!dflag || y2 > db) db <= y2;
    end else if (cmd.draw) dflag <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= 1'b0; read_data <= '0; rect_valid <= 1'b0;
      rect_left <= '0; rect_top <= '0; rect_right <= '0; rect_bottom <= '0;
      pixel_color <= '0;
      unique case (op_t'(op))
        OP_READ, OP_WRITE: begin
          if (sts.is_pix) begin
            status <= sts.past_end;
            if (op == OP_READ && !sts.past_end) read_data <= rdata;
          end else if (sts.is_pal && op == OP_READ) read_data <= {32'd0, pal_q};
        end
        OP_DRAW: if (dflag) begin
          rect_valid <= 1'b1; rect_left <= 10'(dl); rect_top <= 10'(dt);
          rect_right <= 10'(dr); rect_bottom <= 10'(db);
        end
        OP_SCAN: begin
          status <= sts.scan_bad;
          if (!sts.scan_bad) pixel_color <= pal_q;
        end
      endcase
    end
  end
endmodule

/* src/pfdr_ctrl.sv */
// controller state machine sequencing each item
// depends on pfdr_pkg
module pfdr_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic [1:0] opcode,
  output pfdr_pkg::cmd_t cmd,
  input  pfdr_pkg::sts_t sts
);
  import pfdr_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_RD, S_RD_CAP, S_WR, S_DIV1, S_DIV2, S_MERGE,
    S_PAL, S_SCAN_PIX, S_SCAN_PAL, S_OUT, S_HOLD
  } state_t;
  state_t state;
  logic [1:0] op;
  logic div_wait;

  assign in_ready = state == S_IDLE && !sts.init_busy;
  always_comb begin
    cmd = '0;
    cmd.load = in_valid && in_ready;
    unique case (state)
      S_RD: cmd.mem_rd = 1'b1;
      S_RD_CAP: begin
        cmd.capture = 1'b1;
        cmd.mem_rd = !sts.all_read;
      end
      S_WR: cmd.mem_wr = 1'b1;
      S_DIV1: cmd.div_start = !div_wait;
      S_DIV2: cmd.div_start = !div_wait;
      S_MERGE: cmd.merge = 1'b1;
      S_PAL: cmd.pal_wr = op == OP_WRITE && sts.is_pal;
      S_SCAN_PIX: cmd.pal_lookup = 1'b1;
      S_SCAN_PAL: cmd.pal_lookup = 1'b1;
      S_OUT: begin
        cmd.out_load = 1'b1;
        cmd.draw = op == OP_DRAW;
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; op <= '0; div_wait <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          op <= opcode; state <= S_DECODE;
        end
        S_DECODE: begin
          unique case (op_t'(op))
            OP_READ, OP_WRITE: begin
              if (!sts.is_pix) state <= S_PAL;
              else if (sts.past_end || sts.len_zero) state <= S_OUT;
              else if (op == OP_READ) state <= S_RD;
              else state <= S_WR;
            end
            OP_DRAW: state <= S_OUT;
            OP_SCAN: state <= sts.scan_bad ? S_OUT : S_SCAN_PIX;
          endcase
        end
        S_RD: state <= S_RD_CAP;
        S_RD_CAP: if (sts.all_read) state <= S_OUT;
        S_WR: if (sts.last_byte) state <= S_DIV1;
        S_DIV1: begin
          div_wait <= 1'b1;
          if (sts.div_done) begin
            div_wait <= 1'b0; state <= S_DIV2;
          end
        end
        S_DIV2: begin
          div_wait <= 1'b1;
          if (sts.div_done) begin
            div_wait <= 1'b0; state <= S_MERGE;
          end
        end
        S_MERGE: state <= S_OUT;
        S_PAL: state <= S_OUT;
        S_SCAN_PIX: state <= S_SCAN_PAL;
        S_SCAN_PAL: state <= S_OUT;
        S_OUT: begin
          out_valid <= 1'b1; state <= S_HOLD;
        end
        S_HOLD: if (out_ready) begin
          out_valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/palette_framebuffer_dirty_rect_top.sv */
// Indexed 8-bit framebuffer with a 256-entry palette and dirty-rectangle tracking.
// One item at a time: a pixel write updates the dirty rectangle through two restoring
// divisions by the line width. The result is held until out_ready takes it, and the
// controller returns to idle before the next item is accepted. After reset the palette
// is preloaded with its default colours with in_ready low. Pixels never written read
// back undefined.
// depends on pfdr_pkg, pfdr_ctrl, pfdr_datapath
module palette_framebuffer_dirty_rect_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] opcode,
  input  logic [20:0] address,
  input  logic [3:0] length,
  input  logic [63:0] write_data,
  output logic out_valid,
  input  logic out_ready,
  output logic status,
  output logic [63:0] read_data,
  output logic rect_valid,
  output logic [9:0] rect_left,
  output logic [9:0] rect_top,
  output logic [9:0] rect_right,
  output logic [9:0] rect_bottom,
  output logic [31:0] pixel_color,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [10:0] cfg_data
);
  import pfdr_pkg::*;
  cmd_t cmd;
  sts_t sts;

  pfdr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .opcode(opcode),
    .cmd(cmd), .sts(sts)
  );
  pfdr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .opcode(opcode), .address(address), .length(length), .write_data(write_data),
    .status(status), .read_data(read_data), .rect_valid(rect_valid),
    .rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
    .rect_bottom(rect_bottom), .pixel_color(pixel_color)
  );
endmodule

/* sim/tb_palette_framebuffer_dirty_rect_top.sv */
// testbench for the palette framebuffer with dirty-rectangle tracking
// self-checking against an in-bench predictor; depends on pfdr_pkg and the top level
module tb_palette_framebuffer_dirty_rect_top;
  import pfdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        status;
    logic [63:0] rd;
    logic        rv;
    logic [9:0]  rl;
    logic [9:0]  rt;
    logic [9:0]  rr;
    logic [9:0]  rb;
    logic [31:0] pc;
  } fb_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  op_t opcode = OP_READ;
  logic [20:0] address = '0;
  logic [3:0] length = '0;
  logic [63:0] write_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic status;
  logic [63:0] read_data;
  logic rect_valid;
  logic [9:0] rect_left, rect_top, rect_right, rect_bottom;
  logic [31:0] pixel_color;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_WIDTH;
  logic [10:0] cfg_data = '0;

  palette_framebuffer_dirty_rect_top i_dut (.*);

  always #6 clk = ~clk;

  // predictor state
  int unsigned scr_w, scr_h;
  logic [31:0] pal_mem [PALETTE_ENTRIES];
  logic [7:0] pix_mem [int unsigned];
  logic dirty;
  int unsigned d_left, d_top, d_right, d_bottom;

  fb_result_t pending_results[$];
  int errors = 0;
  int checked = 0;
  int sent = 0;
  int draws_valid = 0;
  int past_end_seen = 0;
  int burst_left = 0;

  function automatic int unsigned clamp_dim(logic [10:0] v, int unsigned mx);
    if (v == 0) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic void reset_state();
    logic [7:0] rl [6] = '{8'h00, 8'h33, 8'h66, 8'h99, 8'hCC, 8'hFF};
    logic [7:0] gl [8] = '{8'h00, 8'h24, 8'h49, 8'h6D, 8'h92, 8'hB6, 8'hDB, 8'hFF};
    logic [7:0] bl [5] = '{8'h00, 8'h40, 8'h80, 8'hC0, 8'hFF};
    scr_w = 1024;
    scr_h = 768;
    for (int i = 0; i < 240; i++) pal_mem[i] = {8'h00, rl[i / 40], gl[(i / 5) % 8], bl[i % 5]};
    for (int i = 0; i < 16; i++) pal_mem[240 + i] = 32'h111111 * i;
    dirty = 1'b1;
    d_left = 0;
    d_top = 0;
    d_right = scr_w - 1;
    d_bottom = scr_h - 1;
  endfunction

  function automatic bit pixels_known(int unsigned off, int unsigned len);
    for (int unsigned i = 0; i < len; i++) if (!pix_mem.exists(off + i)) return 0;
    return 1;
  endfunction

  function automatic fb_result_t predict_access(op_t op, logic [20:0] addr, logic [3:0] len_in,
                                                logic [63:0] data);
    fb_result_t r;
    int unsigned total, len, off, last, x1, y1, x2, y2;
    r = '0;
    total = scr_w * scr_h;
    len = (len_in > 8) ? 8 : len_in;
    off = addr - PIX_BASE;
    case (op)
      OP_READ, OP_WRITE: begin
        if (addr < PIX_BASE) begin
          if (addr >= PAL_BASE && addr - PAL_BASE <= PAL_MASK) begin
            if (op == OP_READ) r.rd = {32'h0, pal_mem[addr - PAL_BASE]};
            else pal_mem[addr - PAL_BASE] = data[31:0];
          end
        end else if (off + len > total) begin
          r.status = 1'b1;
        end else if (len > 0) begin
          if (op == OP_READ) begin
            for (int unsigned i = 0; i < len; i++) r.rd[8*i +: 8] = pix_mem[off + i];
          end else begin
            last = off + len - 1;
            x1 = off % scr_w; y1 = off / scr_w;
            x2 = last % scr_w; y2 = last / scr_w;
            for (int unsigned i = 0; i < len; i++) pix_mem[off + i] = data[8*i +: 8];
            if (y1 != y2) begin
              x1 = 0; x2 = scr_w - 1;
            end
            if (!dirty) begin
              d_left = x1; d_top = y1; d_right = x2; d_bottom = y2; dirty = 1'b1;
            end else begin
              if (x1 < d_left) d_left = x1;
              if (y1 < d_top) d_top = y1;
              if (x2 > d_right) d_right = x2;
              if (y2 > d_bottom) d_bottom = y2;
            end
          end
        end
      end
      OP_DRAW: begin
        if (dirty) begin
          r.rv = 1'b1;
          r.rl = 10'(d_left); r.rt = 10'(d_top); r.rr = 10'(d_right); r.rb = 10'(d_bottom);
          dirty = 1'b0;
        end
      end
      default: begin
        if (addr < PIX_BASE || off >= total) r.status = 1'b1;
        else r.pc = pal_mem[pix_mem[off]];
      end
    endcase
    return r;
  endfunction

  task automatic send_beat(op_t op, logic [20:0] addr, logic [3:0] len, logic [63:0] data);
    fb_result_t r;
    int gap;
    r = predict_access(op, addr, len, data);
    if (r.rv) draws_valid++;
    if (r.status) past_end_seen++;
    pending_results.push_back(r);
    in_valid <= 1'b1;
    opcode <= op;
    address <= addr;
    length <= len;
    write_data <= data;
    do @(posedge clk); while (!in_ready);
    sent++;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 24);
      gap = $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_screen(logic [10:0] w, logic [10:0] h);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= CFG_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = clamp_dim(w, MAX_WIDTH);
    scr_h = clamp_dim(h, MAX_HEIGHT);
  endtask

  function automatic int unsigned pick_offset();
    int unsigned total, off;
    total = scr_w * scr_h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: off = $urandom_range(0, ((total < 3000) ? total : 3000) - 1);
      6, 7: off = (total > 12) ? total - $urandom_range(0, 12) : $urandom_range(0, total + 2);
      8: off = $urandom_range(0, total - 1);
      default: off = $urandom_range(0, 32'hFFFFF);
    endcase
    return (off > 32'hFFFFF) ? 32'hFFFFF : off;
  endfunction

  task automatic random_beat();
    int unsigned off, k, ln, total;
    logic [63:0] data;
    op_t op;
    total = scr_w * scr_h;
    data = {$urandom, $urandom};
    off = pick_offset();
    ln = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
    k = $urandom_range(0, 99);
    if (k < 10) begin
      send_beat(OP_DRAW, 21'($urandom), 4'($urandom), data);
    end else if (k < 18) begin
      op = ($urandom_range(0, 1) == 0) ? OP_READ : OP_WRITE;
      if ($urandom_range(0, 3) == 0) send_beat(op, 21'($urandom_range(0, 12'hFFF)), 4'(ln), data);
      else send_beat(op, 21'($urandom_range(PAL_BASE, PAL_BASE + PAL_MASK)), 4'(ln), data);
    end else if (k < 32) begin
      if ($urandom_range(0, 7) == 0)
        send_beat(OP_SCAN, 21'($urandom_range(0, 12'hFFF)), 4'(ln), data);
      else if (off < total && !pix_mem.exists(off))
        send_beat(OP_WRITE, 21'(PIX_BASE + off), 4'(ln), data);
      else
        send_beat(OP_SCAN, 21'(PIX_BASE + off), 4'(ln), data);
    end else if (k < 58) begin
      if (off + ((ln > 8) ? 8 : ln) <= total && !pixels_known(off, (ln > 8) ? 8 : ln))
        send_beat(OP_WRITE, 21'(PIX_BASE + off), 4'(ln), data);
      else
        send_beat(OP_READ, 21'(PIX_BASE + off), 4'(ln), data);
    end else begin
      send_beat(OP_WRITE, 21'(PIX_BASE + off), 4'(ln), data);
    end
  endtask

  task automatic test_directed();
    int unsigned total;
    total = scr_w * scr_h;
    send_beat(OP_DRAW, '0, 4'd0, '0);
    send_beat(OP_DRAW, '1, 4'd15, '1);
    send_beat(OP_READ, PAL_BASE, 4'd4, '0);
    send_beat(OP_READ, PAL_BASE + 21'd239, 4'd0, '0);
    send_beat(OP_READ, PAL_BASE + 21'hFF, 4'd8, '0);
    send_beat(OP_WRITE, PAL_BASE + 21'd5, 4'd4, '1);
    send_beat(OP_READ, PAL_BASE + 21'd5, 4'd1, '0);
    send_beat(OP_READ, 21'h000, 4'd8, '0);
    send_beat(OP_WRITE, 21'hBFF, 4'd8, '1);
    send_beat(OP_READ, 21'hD00, 4'd8, '0);
    send_beat(OP_WRITE, 21'hFFF, 4'd2, 64'h0123_4567_89AB_CDEF);
    send_beat(OP_WRITE, PIX_BASE, 4'd8, 64'h0504_FF03_F000_0105);
    send_beat(OP_READ, PIX_BASE, 4'd8, '0);
    send_beat(OP_SCAN, PIX_BASE + 21'd3, 4'd1, '0);
    send_beat(OP_WRITE, PIX_BASE + 21'd1020, 4'd8, 64'hFEDC_BA98_7654_3210);
    send_beat(OP_DRAW, '0, 4'd1, '0);
    send_beat(OP_WRITE, 21'(PIX_BASE + total - 8), 4'd8, '1);
    send_beat(OP_WRITE, 21'(PIX_BASE + total - 7), 4'd8, '1);
    send_beat(OP_WRITE, 21'(PIX_BASE + total), 4'd0, '1);
    send_beat(OP_READ, 21'(PIX_BASE + total + 1), 4'd0, '0);
    send_beat(OP_WRITE, PIX_BASE + 21'd100, 4'd15, 64'hA5A5_5A5A_C3C3_3C3C);
    send_beat(OP_READ, PIX_BASE + 21'd100, 4'd12, '0);
    send_beat(OP_SCAN, 21'hFFF, 4'd1, '0);
    send_beat(OP_SCAN, 21'(PIX_BASE + total), 4'd1, '0);
    send_beat(OP_WRITE, 21'h100FFF, 4'd1, '1);
    send_beat(OP_DRAW, '0, 4'd0, '0);
  endtask

  task automatic test_screen_size(logic [10:0] w, logic [10:0] h, int items);
    set_screen(w, h);
    repeat (items) random_beat();
  endtask

  // result checking
  always @(posedge clk) begin
    fb_result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{status, read_data, rect_valid, rect_left, rect_top, rect_right, rect_bottom,
              pixel_color};
      checked++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch at result %0d: expected %p, got %p",
                                     checked, want, got);
        end
      end
    end
  end

  // receiver stall pattern
  int stall_mode = 0;
  int stall_count = 0;
  always @(posedge clk) begin
    if (stall_count == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_count = $urandom_range(20, 200);
    end
    stall_count--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= $urandom_range(0, 1);
      2: out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= (stall_count % 8) < 5;
    endcase
  end

  initial begin
    reset_state();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // palette preload sweep after reset
    repeat (300) @(posedge clk);
    test_directed();
    test_screen_size(11'd1024, 11'd768, 80);
    test_screen_size(11'd1, 11'd1, 60);
    test_screen_size(11'd0, 11'd0, 40);
    test_screen_size(11'd2047, 11'd2047, 90);
    test_screen_size(11'd1024, 11'd1024, 90);
    test_screen_size(11'd3, 11'd700, 90);
    test_screen_size(11'd640, 11'd480, 90);
    test_screen_size(11'd17, 11'd9, 90);
    test_screen_size(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)), 90);
    drain();
    $display("covered %0d beats over nine screen sizes, %0d results checked", sent, checked);
    $display("%0d pending rectangles reported, %0d out-of-range accesses", draws_valid,
             past_end_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
